// ===== hdl/psra_pkg.sv =====
// psra_pkg: shared types and constants for the per-stream reorder admit block.
// No dependencies.
package psra_pkg;

  localparam int unsigned NumStreamsDef = 16;
  localparam int unsigned MaxSweep      = 16;
  localparam logic [31:0] HoldWindowRst = 32'd1000;

  typedef enum logic [1:0] {
    KIND_ARRIVAL = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DEC_DROP    = 2'd0,
    DEC_HELD    = 2'd1,
    DEC_PUBLISH = 2'd2,
    DEC_EXPIRED = 2'd3
  } dec_t;

  // One command handed from the front part to the back part.
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  stream;
    logic [31:0] seq;
    logic [31:0] item;
    logic [31:0] now;
  } cmd_t;

  // One result word, before the counters are attached.
  typedef struct packed {
    dec_t        dec;
    logic [3:0]  stream;
    logic [31:0] seq;
    logic [31:0] item;
    logic        last;
  } res_t;

endpackage

// ===== hdl/psra_front.sv =====
// psra_front: two-entry command queue in front of the back part.
// Depends on psra_pkg.
module psra_front import psra_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  cmd_t  in_cmd,
  output logic  q_valid,
  input  logic  q_ready,
  output cmd_t  q_cmd
);

  cmd_t q_mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_mem_r[wp_r] <= in_cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end

endmodule

// ===== hdl/psra_back.sv =====
// psra_back: per-stream state and the sequencer that carries out commands.
// Depends on psra_pkg.
module psra_back import psra_pkg::*; #(
  parameter int unsigned NUM_STREAMS = NumStreamsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr,
  input  logic [31:0] cfg_data,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res_r_o,
  output logic [31:0] held_cnt,
  output logic [31:0] exp_cnt
);

  localparam int unsigned SW = (NUM_STREAMS < MaxSweep) ? NUM_STREAMS : MaxSweep;
  localparam int unsigned IW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_OUT, S_SWEEP, S_SOUT} state_t;

  state_t      state_r;
  cmd_t        cmd_r;
  logic [31:0] win_r;
  logic [NUM_STREAMS-1:0] mvalid_r, hvalid_r;
  logic [31:0] mnum_r  [NUM_STREAMS];
  logic [31:0] hnum_r  [NUM_STREAMS];
  logic [31:0] hitem_r [NUM_STREAMS];
  logic [31:0] htime_r [NUM_STREAMS];
  logic [31:0] held_r, exp_r;
  logic [4:0]  sidx_r;
  logic [4:0]  scnt_r;   // expired streams found by the counting pass
  logic [4:0]  left_r;   // expired results the release pass still has to send
  res_t        ov_res_r, res_r;
  logic        rv_r;
  // registered view of the addressed entry
  logic        e_mv_r, e_hv_r;
  logic [31:0] e_mn_r, e_hn_r, e_hi_r, e_ht_r;

  assign q_ready   = (state_r == S_IDLE);
  assign res_valid = rv_r;
  assign res_r_o   = res_r;
  assign held_cnt  = held_r;
  assign exp_cnt   = exp_r;

  logic [3:0]    sstr;
  logic [IW-1:0] q_idx, e_idx, sw_idx;
  logic          sw_exp;
  assign sstr   = sidx_r[3:0];
  assign q_idx  = IW'(q_cmd.stream);
  assign e_idx  = IW'(cmd_r.stream);
  assign sw_idx = IW'(sidx_r);
  // The swept stream holds a packet whose age has reached the window.
  assign sw_exp = hvalid_r[sw_idx] && ((cmd_r.now - htime_r[sw_idx]) >= win_r);

  // stream fits
  logic in_rng;
  assign in_rng = ({28'd0, cmd_r.stream} < NUM_STREAMS);

  always_ff @(posedge clk) begin
    logic        ld;
    logic        mv, mv_n, hv_n, hset, two;
    logic [31:0] mn, mn_n;
    logic [32:0] mn1;
    res_t        a, b;
    logic [3:0]  s;
    ld = 1'b0;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mvalid_r <= '0;
      hvalid_r <= '0;
      held_r   <= '0;
      exp_r    <= '0;
      rv_r     <= 1'b0;
      sidx_r   <= '0;
      scnt_r   <= '0;
      left_r   <= '0;
      win_r    <= HoldWindowRst;
    end else begin
      if (cfg_wr) win_r <= cfg_data;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            if ({28'd0, q_cmd.stream} < NUM_STREAMS) begin
              e_mv_r <= mvalid_r[q_idx];
              e_hv_r <= hvalid_r[q_idx];
              e_mn_r <= mnum_r[q_idx];
              e_hn_r <= hnum_r[q_idx];
              e_hi_r <= hitem_r[q_idx];
              e_ht_r <= htime_r[q_idx];
            end
            case (q_cmd.kind)
              KIND_ARRIVAL: state_r <= S_EVAL;
              KIND_TICK: begin
                sidx_r  <= '0;
                scnt_r  <= '0;
                state_r <= S_SWEEP;
              end
              KIND_CLEAR: hvalid_r <= '0;
              default: ;
            endcase
          end
        end
        S_EVAL: begin
          if (!rv_r || res_ready) begin
            s    = cmd_r.stream;
            mv   = e_mv_r;
            mn   = e_mn_r;
            mv_n = e_mv_r;
            mn_n = e_mn_r;
            hv_n = e_hv_r;
            hset = 1'b0;
            two  = 1'b0;
            mn1  = '0;
            a    = '{DEC_DROP, s, cmd_r.seq, 32'd0, 1'b1};
            b    = a;
            if (!in_rng) begin
              // out-of-range stream: dropped, nothing changes
            end else if (e_hv_r && cmd_r.seq == e_hn_r) begin
              // duplicate of the held packet
            end else if (e_hv_r && cmd_r.seq < e_hn_r) begin
              if (!(e_mv_r && cmd_r.seq < e_mn_r)) begin
                a    = '{DEC_PUBLISH, s, cmd_r.seq, cmd_r.item, 1'b1};
                mv_n = 1'b1;
                mn_n = cmd_r.seq;
                if ({1'b0, e_hn_r} == {1'b0, cmd_r.seq} + 33'd1) begin
                  a.last = 1'b0;
                  two  = 1'b1;
                  b    = '{DEC_PUBLISH, s, e_hn_r, e_hi_r, 1'b1};
                  hv_n = 1'b0;
                  mn_n = e_hn_r;
                end
              end
            end else begin
              if (e_hv_r) begin
                // flush the held packet first; the mark only moves forward
                two  = 1'b1;
                a    = '{DEC_PUBLISH, s, e_hn_r, e_hi_r, 1'b0};
                hv_n = 1'b0;
                if (!(e_mv_r && e_hn_r < e_mn_r)) mn = e_hn_r;
                mv = 1'b1;
              end
              mn1  = {1'b0, mn} + 33'd1;
              mv_n = 1'b1;
              mn_n = mn;
              if (mv && cmd_r.seq < mn) begin
                b = '{DEC_DROP, s, cmd_r.seq, 32'd0, 1'b1};
              end else if (!mv || {1'b0, cmd_r.seq} <= mn1) begin
                b    = '{DEC_PUBLISH, s, cmd_r.seq, cmd_r.item, 1'b1};
                mn_n = cmd_r.seq;
              end else begin
                b    = '{DEC_HELD, s, cmd_r.seq, 32'd0, 1'b1};
                hv_n = 1'b1;
                hset = 1'b1;
              end
              if (!two) a = b;
            end
            if (in_rng) begin
              mvalid_r[e_idx] <= mv_n;
              mnum_r[e_idx]   <= mn_n;
              hvalid_r[e_idx] <= hv_n;
            end
            if (hset) begin
              hnum_r[e_idx]  <= cmd_r.seq;
              hitem_r[e_idx] <= cmd_r.item;
              htime_r[e_idx] <= cmd_r.now;
              held_r         <= held_r + 32'd1;
            end
            res_r    <= a;
            ld       = 1'b1;
            ov_res_r <= b;
            state_r  <= two ? S_OUT : S_IDLE;
          end
        end
        S_OUT: begin
          if (!rv_r || res_ready) begin
            res_r   <= ov_res_r;
            ld      = 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_SWEEP: begin
          // Counting pass, one stream per cycle. The expired counter takes its
          // final value before the first result of the sweep is shown.
          if (sidx_r == 5'(SW)) begin
            if (scnt_r == 5'd0) begin
              state_r <= S_IDLE;
            end else if (!rv_r || res_ready) begin
              exp_r   <= exp_r + {27'd0, scnt_r};
              left_r  <= scnt_r;
              sidx_r  <= '0;
              state_r <= S_SOUT;
            end
          end else begin
            if (sw_exp) scnt_r <= scnt_r + 5'd1;
            sidx_r <= sidx_r + 5'd1;
          end
        end
        S_SOUT: begin
          // Release pass: the same streams expire again, so the count tells
          // which result is the last one.
          if (left_r == 5'd0) begin
            state_r <= S_IDLE;
          end else if (!rv_r || res_ready) begin
            if (sw_exp) begin
              res_r <= '{DEC_EXPIRED, sstr, hnum_r[sw_idx], hitem_r[sw_idx],
                         left_r == 5'd1};
              ld = 1'b1;
              left_r <= left_r - 5'd1;
              hvalid_r[sw_idx] <= 1'b0;
              mvalid_r[sw_idx] <= 1'b1;
              if (!(mvalid_r[sw_idx] && hnum_r[sw_idx] < mnum_r[sw_idx]))
                mnum_r[sw_idx] <= hnum_r[sw_idx];
            end
            sidx_r <= sidx_r + 5'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (ld) rv_r <= 1'b1;
      else if (rv_r && res_ready) rv_r <= 1'b0;
    end
  end

endmodule

// ===== hdl/per_stream_reorder_admit.sv =====
// per_stream_reorder_admit: top level, front queue plus back sequencer.
// Depends on psra_pkg, psra_front, psra_back.
//
// channel | dir | fields (low bit up)
// in_     | in  | tuser: kind[1:0]; tdata: stream[3:0], seq[35:4], item[67:36],
//         |     |        now[99:68], zero fill to 104
// out_    | out | tuser: decision[1:0]; tlast: last; tdata: stream[3:0],
//         |     |        seq, item, held_count_total, expired_count_total
// cfg_    | in  | hold window in ticks, written when cfg_wr is high
//
// An arrival goes through a load step and a decide step in the back part,
// plus an output step when a held packet comes out with it. A sweep makes
// a counting pass over min(NUM_STREAMS,16) streams and, if a hold expired,
// a release pass up to the last expired one, one stream per cycle in each
// (the release pass only while the output does not stall). A clear is done
// as it is taken. Reset is synchronous; marks and holds start invalid,
// counters at zero. A word waiting on out_tready holds back the next word of
// the back part; the two-entry front queue keeps accepting words until full.
module per_stream_reorder_admit import psra_pkg::*; #(
  parameter int unsigned NUM_STREAMS = NumStreamsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // kind
  input  logic [103:0] in_tdata,   // stream, seq, item, now, zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // decision
  output logic         out_tlast,
  output logic [135:0] out_tdata,  // stream, seq, item, held, expired, zero fill
  input  logic         cfg_wr,
  input  logic [31:0]  cfg_data
);

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  res_t res;
  logic [31:0] held_cnt, exp_cnt;

  assign in_cmd = '{kind_t'(in_tuser), in_tdata[3:0], in_tdata[35:4],
                    in_tdata[67:36], in_tdata[99:68]};

  psra_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  psra_back #(.NUM_STREAMS(NUM_STREAMS)) u_back (
    .clk, .rst_n, .cfg_wr, .cfg_data, .q_valid, .q_ready, .q_cmd,
    .res_valid(out_tvalid), .res_ready(out_tready), .res_r_o(res),
    .held_cnt, .exp_cnt
  );

  // Counters are always final for the word shown: the back part changes a
  // counter only when no earlier word is waiting, and before the first word
  // of its command comes out.
  assign out_tuser = res.dec;
  assign out_tlast = res.last;
  assign out_tdata = {4'd0, exp_cnt, held_cnt, res.item, res.seq, res.stream};

`ifndef SYNTHESIS
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tuser))
    else $error("result changed while stalled");
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> !(q_valid == 1'b0))
    else $error("queue full but empty");
  a_drop_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == DEC_DROP || out_tuser == DEC_HELD) |->
    out_tdata[67:36] == 32'd0)
    else $error("item on drop or hold");
`endif

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for per_stream_reorder_admit.
// Depends on psra_pkg and the per_stream_reorder_admit RTL. It predicts every
// result word in its own admission model and compares the words field by field.
`timescale 1ns / 100ps

module tb;
  import psra_pkg::*;

  localparam int unsigned NSTR = 16;
  localparam int unsigned MAX_CYCLES = 1000000;
  localparam int unsigned DRAIN_CYCLES = 200;  // longer than three sweeps in a row
  localparam int unsigned LONG_HOLD = 400;

  // One input word as the testbench sees it.
  typedef struct {
    kind_t       kind;
    logic [3:0]  stream;
    logic [31:0] seq;
    logic [31:0] tag;
    logic [31:0] now;
  } arrival_t;

  // One expected result word.
  typedef struct {
    dec_t        dec;
    logic [3:0]  stream;
    logic [31:0] seq;
    logic [31:0] tag;
    logic        last;
    logic [31:0] held;
    logic [31:0] expired;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic [135:0] out_tdata;
  logic         cfg_wr = 1'b0;
  logic [31:0]  cfg_data = '0;

  per_stream_reorder_admit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .out_tdata (out_tdata),
    .cfg_wr    (cfg_wr),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Admission model. It mirrors the block's per-stream marks and holds and is
  // advanced once per accepted input word, in acceptance order.
  // ---------------------------------------------------------------------------
  logic        mark_ok   [NSTR];
  logic [31:0] mark_num  [NSTR];
  logic        hold_ok   [NSTR];
  logic [31:0] hold_num  [NSTR];
  logic [31:0] hold_tag  [NSTR];
  logic [31:0] hold_stamp[NSTR];
  logic [31:0] held_total = '0;
  logic [31:0] expired_total = '0;
  logic [31:0] window = HoldWindowRst;

  verdict_t awaited_words[$];  // results still owed by the block, oldest first
  verdict_t batch[$];          // results of the word being predicted

  initial begin
    for (int i = 0; i < NSTR; i++) begin
      mark_ok[i] = 1'b0;
      hold_ok[i] = 1'b0;
      mark_num[i] = '0;
      hold_num[i] = '0;
      hold_tag[i] = '0;
      hold_stamp[i] = '0;
    end
  end

  function automatic void note(dec_t d, int s, logic [31:0] q, logic [31:0] t);
    verdict_t v;
    v.dec = d;
    v.stream = s[3:0];
    v.seq = q;
    v.tag = (d == DEC_PUBLISH || d == DEC_EXPIRED) ? t : 32'd0;
    v.last = 1'b0;
    v.held = '0;
    v.expired = '0;
    batch.insert(batch.size(), v);
  endfunction

  // Moves the stream's mark to q unless q is stale.
  function automatic bit admit_mark(int s, logic [31:0] q);
    if (mark_ok[s] && q < mark_num[s]) return 1'b0;
    mark_ok[s] = 1'b1;
    mark_num[s] = q;
    return 1'b1;
  endfunction

  function automatic void judge_arrival(int s, logic [31:0] q, logic [31:0] t, logic [31:0] now);
    logic [31:0] b;
    bit settled;
    settled = 1'b0;
    if (hold_ok[s]) begin
      b = hold_num[s];
      if (q == b) begin
        // A duplicate of the held packet is dropped; the hold stays.
        note(DEC_DROP, s, q, 32'd0);
        settled = 1'b1;
      end else if (q < b) begin
        settled = 1'b1;
        if (!admit_mark(s, q)) begin
          note(DEC_DROP, s, q, 32'd0);
        end else begin
          note(DEC_PUBLISH, s, q, t);
          if ({1'b0, b} == {1'b0, q} + 33'd1) begin
            // The gap is filled, so the held packet follows right behind.
            note(DEC_PUBLISH, s, b, hold_tag[s]);
            hold_ok[s] = 1'b0;
            void'(admit_mark(s, b));
          end
        end
      end else begin
        // A newer arrival flushes the held packet first.
        note(DEC_PUBLISH, s, b, hold_tag[s]);
        void'(admit_mark(s, b));
        hold_ok[s] = 1'b0;
      end
    end
    if (settled) return;
    if (!mark_ok[s]) begin
      void'(admit_mark(s, q));
      note(DEC_PUBLISH, s, q, t);
    end else if (q < mark_num[s]) begin
      note(DEC_DROP, s, q, 32'd0);
    end else if ({1'b0, q} <= {1'b0, mark_num[s]} + 33'd1) begin
      void'(admit_mark(s, q));
      note(DEC_PUBLISH, s, q, t);
    end else begin
      hold_ok[s] = 1'b1;
      hold_num[s] = q;
      hold_tag[s] = t;
      hold_stamp[s] = now;
      held_total = held_total + 32'd1;
      note(DEC_HELD, s, q, 32'd0);
    end
  endfunction

  function automatic void predict_word(arrival_t a);
    logic [31:0] age;
    batch.delete();
    case (a.kind)
      KIND_ARRIVAL: judge_arrival(int'(a.stream), a.seq, a.tag, a.now);
      KIND_TICK: begin
        for (int s = 0; s < NSTR; s++) begin
          age = a.now - hold_stamp[s];
          if (hold_ok[s] && age >= window) begin
            void'(admit_mark(s, hold_num[s]));
            note(DEC_EXPIRED, s, hold_num[s], hold_tag[s]);
            hold_ok[s] = 1'b0;
            expired_total = expired_total + 32'd1;
          end
        end
      end
      KIND_CLEAR: begin
        for (int s = 0; s < NSTR; s++) hold_ok[s] = 1'b0;
      end
      default: ;  // unused kind, no effect
    endcase
    // Counters are the values after the whole word; last marks the final one.
    for (int i = 0; i < batch.size(); i++) begin
      batch[i].last = (i == batch.size() - 1);
      batch[i].held = held_total;
      batch[i].expired = expired_total;
      awaited_words.insert(awaited_words.size(), batch[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Words come from stim_q; after each word it draws an idle gap.
  // ---------------------------------------------------------------------------
  arrival_t stim_q[$];
  arrival_t on_bus;
  int       gap_left = 0;
  int       words_sent = 0;
  bit       no_idle = 1'b0;   // set for stretches where neither side idles

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_word(on_bus);
        words_sent <= words_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          on_bus = stim_q[0];
          stim_q.delete(0);
          in_tuser <= on_bus.kind;
          in_tdata <= {4'b0, on_bus.now, on_bus.tag, on_bus.seq, on_bus.stream};
          in_tvalid <= 1'b1;
          gap_left = no_idle ? 0 : $urandom_range(0, 9);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Stalls a random number of cycles after each word, and once holds
  // off for a long stretch so that the block backs up into its input.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_sent >= 40) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  int stall_left = 0;
  int errors = 0;

  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (stall_left > 0) stall_left = stall_left - 1;
      if (out_tvalid && out_tready) begin
        if (awaited_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: dec %0d stream %0d seq %h", out_tuser,
                     out_tdata[3:0], out_tdata[35:4]);
        end else begin
          v = awaited_words[0];
          awaited_words.delete(0);
          if (out_tuser != v.dec || out_tdata[3:0] != v.stream ||
              out_tdata[35:4] != v.seq || out_tdata[67:36] != v.tag ||
              out_tlast != v.last || out_tdata[99:68] != v.held ||
              out_tdata[131:100] != v.expired) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp: dec %0d str %0d seq %h tag %h last %0d held %0d exp %0d",
                       v.dec, v.stream, v.seq, v.tag, v.last, v.held, v.expired);
              $display("         got: dec %0d str %0d seq %h tag %h last %0d held %0d exp %0d",
                       out_tuser, out_tdata[3:0], out_tdata[35:4], out_tdata[67:36],
                       out_tlast, out_tdata[99:68], out_tdata[131:100]);
            end
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 9);
      end
      out_tready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // Watchdog.
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("[per_stream_reorder_admit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [31:0] gen_base [NSTR];
  logic [31:0] gen_stamp[NSTR];
  logic [31:0] clock_now;

  task automatic add(kind_t k, int s, logic [31:0] q, logic [31:0] t, logic [31:0] now);
    arrival_t a;
    a.kind = k;
    a.stream = s[3:0];
    a.seq = q;
    a.tag = t;
    a.now = now;
    stim_q.insert(stim_q.size(), a);
  endtask

  // Waits until every queued word is taken and every result has come out, then
  // lets the sweeps that yield nothing run to their end.
  task automatic drain();
    while (stim_q.size() > 0 || in_tvalid || gap_left > 0 || awaited_words.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(logic [31:0] w);
    @(posedge clk);
    cfg_wr <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_wr <= 1'b0;
    window = w;
  endtask

  // Mostly well-formed runs near each stream's progress, with some noise.
  task automatic add_random(int count);
    int s;
    int r;
    logic [31:0] q;
    for (int n = 0; n < count; ) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, NSTR - 1);
      clock_now = clock_now + $urandom_range(0, 40);
      if (r < 78) begin
        if ($urandom_range(0, 99) < 6) begin
          q = $urandom;
          gen_base[s] = q;
        end else begin
          gen_base[s] = gen_base[s] + $urandom_range(0, 2);
          q = gen_base[s] + $urandom_range(0, 5) - 2;
        end
        gen_stamp[s] = clock_now;
        add(KIND_ARRIVAL, s, q, $urandom, clock_now);
        n++;
      end else if (r < 92) begin
        // Sometimes aim the tick at the largest age a stream's hold can have.
        if ($urandom_range(0, 3) == 0) add(KIND_TICK, s, $urandom, $urandom, gen_stamp[s] - 1);
        else add(KIND_TICK, s, $urandom, $urandom, clock_now);
        n++;
      end else if (r < 96) begin
        add(KIND_CLEAR, s, $urandom, $urandom, clock_now);
        n++;
      end else begin
        add(KIND_NONE, s, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    logic [31:0] windows[5];
    for (int i = 0; i < NSTR; i++) begin
      gen_base[i] = $urandom_range(0, 1000);
      gen_stamp[i] = '0;
    end
    clock_now = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset hold window of 1000 ticks.
    add(KIND_ARRIVAL, 0, 32'd10, 32'hA0, 32'd5000);         // first of stream
    add(KIND_ARRIVAL, 0, 32'd10, 32'hA1, 32'd5001);         // equal to mark
    add(KIND_ARRIVAL, 0, 32'd11, 32'hA2, 32'd5002);         // contiguous
    add(KIND_ARRIVAL, 0, 32'd9, 32'hA3, 32'd5003);          // stale
    add(KIND_ARRIVAL, 0, 32'd14, 32'hA4, 32'd5004);         // gap, held
    add(KIND_ARRIVAL, 0, 32'd14, 32'hA5, 32'd5005);         // duplicate of held
    add(KIND_ARRIVAL, 0, 32'd12, 32'hA6, 32'd5006);         // partial fill
    add(KIND_ARRIVAL, 0, 32'd13, 32'hA7, 32'd5007);         // fill releases held
    add(KIND_ARRIVAL, 0, 32'd20, 32'hA8, 32'd5008);         // held
    add(KIND_ARRIVAL, 0, 32'd25, 32'hA9, 32'd5009);         // flush, then held
    add(KIND_ARRIVAL, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add(KIND_ARRIVAL, 1, 32'd0, 32'd0, 32'd0);              // stale at the top
    add(KIND_ARRIVAL, 1, 32'hFFFF_FFFF, 32'h5555_5555, 32'd1);
    add(KIND_ARRIVAL, 2, 32'd0, 32'hB0, 32'd5010);
    add(KIND_ARRIVAL, 2, 32'd5, 32'hB1, 32'd5010);          // held
    add(KIND_TICK, 0, 32'd0, 32'd0, 32'd6008);              // one tick short
    add(KIND_TICK, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd6010); // both expire
    add(KIND_ARRIVAL, 3, 32'd0, 32'hC0, 32'd7000);
    add(KIND_ARRIVAL, 3, 32'd3, 32'hC1, 32'd7000);          // held
    add(KIND_CLEAR, 3, 32'd0, 32'd0, 32'd7001);
    add(KIND_ARRIVAL, 3, 32'd3, 32'hC2, 32'd7002);          // held again
    add(KIND_NONE, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add(KIND_ARRIVAL, 15, 32'd7, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    add(KIND_ARRIVAL, 15, 32'd2, 32'h5555_5555, 32'h5555_5555);
    add(KIND_CLEAR, 0, 32'd0, 32'd0, 32'd0);
    add_random(60);
    drain();

    // Random phases across the range of the hold window, the extremes included.
    windows[0] = 32'd0;
    windows[1] = 32'd50;
    windows[2] = 32'hFFFF_FFFF;
    windows[3] = HoldWindowRst;
    windows[4] = $urandom_range(1, 300);
    for (int p = 0; p < 5; p++) begin
      set_window(windows[p]);
      no_idle = (p % 2 == 1);
      add_random(65);
      drain();
    end

    if (errors == 0 && awaited_words.size() == 0) begin
      $display("[per_stream_reorder_admit] OK");
    end else begin
      $display("[per_stream_reorder_admit] ERROR");
    end
    $finish;
  end

endmodule
